// File: sv/mhc_pkg.sv
// Shared types, codes and magic-byte classification for the media header classifier.
package mhc_pkg;

    // Only header bytes 0..25 ever reach a result (BMP height ends at byte 25).
    localparam int HDR_BYTES = 26;
    localparam int POS_W     = 33;

    localparam logic [7:0] TIFF_MAGIC = 8'd42;

    typedef logic [HDR_BYTES-1:0][7:0] t_hdr;

    typedef enum logic [4:0] {
        FMT_UNKNOWN = 5'd0,
        FMT_JPEG    = 5'd1,
        FMT_PNG     = 5'd2,
        FMT_GIF     = 5'd3,
        FMT_WEBP    = 5'd4,
        FMT_AVIF    = 5'd5,
        FMT_HEIF    = 5'd6,
        FMT_M4A     = 5'd7,
        FMT_MP4     = 5'd8,
        FMT_BMP     = 5'd9,
        FMT_TIFF    = 5'd10,
        FMT_MP3     = 5'd11,
        FMT_FLAC    = 5'd12,
        FMT_OGG     = 5'd13,
        FMT_WAV     = 5'd14,
        FMT_AIFF    = 5'd15,
        FMT_MKV     = 5'd16,
        FMT_AVI     = 5'd17
    } t_format;

    typedef enum logic [1:0] {
        CLS_UNKNOWN = 2'd0,
        CLS_IMAGE   = 2'd1,
        CLS_AUDIO   = 2'd2,
        CLS_VIDEO   = 2'd3
    } t_class;

    // JPEG frame header fields as seen by the marker walker
    typedef struct packed {
        logic        seen;
        logic [15:0] height;
        logic [15:0] width;
    } t_frame;

    function automatic logic m4(t_hdr h, int i, logic [31:0] tag);
        return {h[i], h[i+1], h[i+2], h[i+3]} == tag;
    endfunction

    function automatic t_format classify(t_hdr h);
        logic    riff;
        t_format fmt;
        riff = m4(h, 0, "RIFF");
        priority if (h[0] == 8'hFF && h[1] == 8'hD8 && h[2] == 8'hFF)
            fmt = FMT_JPEG;
        else if (h[0] == 8'h89 && h[1] == "P" && h[2] == "N" && h[3] == "G")
            fmt = FMT_PNG;
        else if (h[0] == "G" && h[1] == "I" && h[2] == "F")
            fmt = FMT_GIF;
        else if (riff && m4(h, 8, "WEBP"))
            fmt = FMT_WEBP;
        else if (m4(h, 4, "ftyp")) begin
            priority if (m4(h, 8, "avif"))
                fmt = FMT_AVIF;
            else if (h[8] == "h" && h[9] == "e" && (h[10] == "i" || h[10] == "v"))
                fmt = FMT_HEIF;
            else if (h[8] == "M" && h[9] == "4" && h[11] == "A")
                fmt = FMT_M4A;
            else
                fmt = FMT_MP4;
        end
        else if (h[0] == "B" && h[1] == "M")
            fmt = FMT_BMP;
        else if ((h[0] == "I" && h[1] == "I" && h[2] == TIFF_MAGIC && h[3] == 8'h00) ||
                 (h[0] == "M" && h[1] == "M" && h[2] == 8'h00 && h[3] == TIFF_MAGIC))
            fmt = FMT_TIFF;
        else if ((h[0] == "I" && h[1] == "D" && h[2] == "3") ||
                 (h[0] == 8'hFF && (h[1] & 8'hE0) == 8'hE0))
            fmt = FMT_MP3;
        else if (m4(h, 0, "fLaC"))
            fmt = FMT_FLAC;
        else if (m4(h, 0, "OggS"))
            fmt = FMT_OGG;
        else if (riff && m4(h, 8, "WAVE"))
            fmt = FMT_WAV;
        else if (m4(h, 0, "FORM") && h[8] == "A" && h[9] == "I" && h[10] == "F")
            fmt = FMT_AIFF;
        else if (h[0] == 8'h1A && h[1] == 8'h45 && h[2] == 8'hDF && h[3] == 8'hA3)
            fmt = FMT_MKV;
        else if (riff && m4(h, 8, "AVI "))
            fmt = FMT_AVI;
        else
            fmt = FMT_UNKNOWN;
        return fmt;
    endfunction

    function automatic t_class class_of(t_format fmt);
        t_class cls;
        unique case (fmt)
            FMT_UNKNOWN:                                      cls = CLS_UNKNOWN;
            FMT_M4A, FMT_MP3, FMT_FLAC, FMT_OGG, FMT_WAV, FMT_AIFF: cls = CLS_AUDIO;
            FMT_MP4, FMT_MKV, FMT_AVI:                        cls = CLS_VIDEO;
            FMT_JPEG, FMT_PNG, FMT_GIF, FMT_WEBP, FMT_AVIF, FMT_HEIF,
            FMT_BMP, FMT_TIFF:                                cls = CLS_IMAGE;
            default:                                          cls = CLS_UNKNOWN;
        endcase
        return cls;
    endfunction

endpackage

// File: sv/mhc_jpeg_walk.sv
// JPEG marker walker: skips segments until SOF0 or SOF2 and captures the frame size.
module mhc_jpeg_walk (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  logic            i_clear,
    input  logic [7:0]      i_byte,
    output mhc_pkg::t_frame o_frame
);

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_SOI    = 4'd1,
        PH_PREFIX = 4'd2,
        PH_CODE   = 4'd3,
        PH_LEN_HI = 4'd4,
        PH_LEN_LO = 4'd5,
        PH_SKIP   = 4'd6,
        PH_PREC   = 4'd7,
        PH_H_HI   = 4'd8,
        PH_H_LO   = 4'd9,
        PH_W_HI   = 4'd10,
        PH_W_LO   = 4'd11,
        PH_IDLE   = 4'd12
    } t_phase;

    localparam logic [7:0] MK_PREFIX = 8'hFF;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF2   = 8'hC2;

    t_phase          r_phase,  n_phase;
    logic [15:0]     r_skip,   n_skip;
    logic [7:0]      r_len_hi, n_len_hi;
    mhc_pkg::t_frame r_frame,  n_frame;
    logic [15:0]     seg_len;
    logic [15:0]     skip_dec;

    assign seg_len  = {r_len_hi, i_byte};
    assign skip_dec = r_skip - 16'd1;

    always_comb begin
        n_phase  = r_phase;
        n_skip   = r_skip;
        n_len_hi = r_len_hi;
        n_frame  = r_frame;
        unique case (r_phase)
            PH_START:  n_phase = (i_byte == MK_PREFIX) ? PH_SOI : PH_IDLE;
            PH_SOI:    n_phase = (i_byte == MK_SOI) ? PH_PREFIX : PH_IDLE;
            PH_PREFIX: n_phase = (i_byte == MK_PREFIX) ? PH_CODE : PH_IDLE;
            PH_CODE: begin
                if (i_byte == MK_SOF0 || i_byte == MK_SOF2) begin
                    n_frame.seen = 1'b1;
                end
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len_hi = i_byte;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (r_frame.seen) begin
                    n_phase = PH_PREC;
                end else if (seg_len > 16'd2) begin
                    n_skip  = seg_len - 16'd2;
                    n_phase = PH_SKIP;
                end else begin
                    n_phase = PH_PREFIX;
                end
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0) begin
                    n_phase = PH_PREFIX;
                end
            end
            PH_PREC:   n_phase = PH_H_HI;
            PH_H_HI: begin
                n_frame.height = {i_byte, 8'h00};
                n_phase        = PH_H_LO;
            end
            PH_H_LO: begin
                n_frame.height = {r_frame.height[15:8], i_byte};
                n_phase        = PH_W_HI;
            end
            PH_W_HI: begin
                n_frame.width = {i_byte, 8'h00};
                n_phase       = PH_W_LO;
            end
            PH_W_LO: begin
                n_frame.width = {r_frame.width[15:8], i_byte};
                n_phase       = PH_IDLE;
            end
            PH_IDLE:   n_phase = PH_IDLE;
            default:   n_phase = PH_IDLE;
        endcase
    end

    // frame fields including the current byte, for the last byte of a file
    assign o_frame = n_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_skip   <= '0;
            r_len_hi <= '0;
            r_frame  <= '0;
        end else if (i_advance) begin
            if (i_clear) begin
                r_phase  <= PH_START;
                r_skip   <= '0;
                r_len_hi <= '0;
                r_frame  <= '0;
            end else begin
                r_phase  <= n_phase;
                r_skip   <= n_skip;
                r_len_hi <= n_len_hi;
                r_frame  <= n_frame;
            end
        end
    end

endmodule

// File: sv/media_header_classifier.sv
// Media header classifier: magic-byte format detection and picture size extraction.
// Throughput: one byte per cycle unless stalled; a new file may start on the cycle after a last byte.
// Pipeline: two register stages; the snapshot stage takes a file's last byte, and the result
//   register then raises o_out_valid once it is empty or its request is taken.
// Reset (synchronous, i_rst_n low): header store, byte count and JPEG walk return to the start
//   of a file, both pipeline stages empty, and the size limit returns to all ones.
module media_header_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte requests
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    // result requests
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_format_code,
    output logic [1:0]  o_media_class,
    output logic [31:0] o_pixel_width,
    output logic [31:0] o_pixel_height,
    // size limit register
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    localparam logic [mhc_pkg::POS_W-1:0] POS_MAX = '1;

    // ---------------------------------------------------------------------
    // Per-file state: header bytes, saturating byte count, size limit
    // ---------------------------------------------------------------------
    logic [31:0]                  r_size_limit;
    mhc_pkg::t_hdr                r_hdr, n_hdr;
    logic [mhc_pkg::POS_W-1:0]    r_pos, n_pos;
    logic                         in_accept;
    logic                         in_last;
    logic                         size_ok;
    mhc_pkg::t_frame              frame_next;

    // Snapshot stage: header and frame fields of a finished file
    logic                         r_s_valid;
    mhc_pkg::t_hdr                r_s_hdr;
    logic                         r_s_size_ok;
    mhc_pkg::t_frame              r_s_frame;

    // Result stage
    logic                         r_o_valid;
    mhc_pkg::t_format             r_o_fmt;
    mhc_pkg::t_class              r_o_cls;
    logic [31:0]                  r_o_width;
    logic [31:0]                  r_o_height;

    logic                         out_adv;
    logic                         s_free;
    mhc_pkg::t_format             fmt;
    mhc_pkg::t_class              cls;
    logic [31:0]                  dim_w;
    logic [31:0]                  dim_h;
    logic [31:0]                  bmp_h;

    // Result register moves when empty or when its request is taken; the
    // snapshot frees up in the same cycle, so a last byte is never held up
    // while results drain at full rate.
    assign out_adv    = !r_o_valid || !i_out_stall;
    assign s_free     = !r_s_valid || out_adv;
    assign o_in_stall = !s_free;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_last    = i_end_of_file;

    // Write the incoming byte into its header slot; later bytes leave the store alone
    always_comb begin
        for (int i = 0; i < mhc_pkg::HDR_BYTES; i++) begin
            n_hdr[i] = (r_pos == mhc_pkg::POS_W'(i)) ? i_data_byte : r_hdr[i];
        end
    end

    // Count saturates at all ones; compare counts including the current byte
    assign n_pos   = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign size_ok = n_pos <= {1'b0, r_size_limit};

    mhc_jpeg_walk u_jpeg_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (in_accept),
        .i_clear   (in_last),
        .i_byte    (i_data_byte),
        .o_frame   (frame_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_limit <= '1;
            r_hdr        <= '0;
            r_pos        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_size_limit <= i_cfg_wdata;
            end
            if (in_accept) begin
                // clear everything at a file boundary so short files read zeros
                r_hdr <= in_last ? '0 : n_hdr;
                r_pos <= in_last ? '0 : n_pos;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Snapshot stage: hold the finished file's header until classified
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (in_accept && in_last) begin
            r_s_valid <= 1'b1;
        end else if (out_adv) begin
            r_s_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && in_last) begin
            r_s_hdr     <= n_hdr;
            r_s_size_ok <= size_ok;
            r_s_frame   <= frame_next;
        end
    end

    // ---------------------------------------------------------------------
    // Classification and dimensions
    // ---------------------------------------------------------------------
    assign fmt = mhc_pkg::classify(r_s_hdr);
    assign cls = mhc_pkg::class_of(fmt);

    // BMP height is signed (negative for top-down bitmaps); report its magnitude
    assign bmp_h = {r_s_hdr[25], r_s_hdr[24], r_s_hdr[23], r_s_hdr[22]};

    always_comb begin
        dim_w = '0;
        dim_h = '0;
        if (cls == mhc_pkg::CLS_IMAGE && r_s_size_ok) begin
            unique case (fmt)
                mhc_pkg::FMT_JPEG: begin
                    if (r_s_frame.seen) begin
                        dim_w = {16'h0000, r_s_frame.width};
                        dim_h = {16'h0000, r_s_frame.height};
                    end
                end
                mhc_pkg::FMT_PNG: begin
                    dim_w = {r_s_hdr[16], r_s_hdr[17], r_s_hdr[18], r_s_hdr[19]};
                    dim_h = {r_s_hdr[20], r_s_hdr[21], r_s_hdr[22], r_s_hdr[23]};
                end
                mhc_pkg::FMT_GIF: begin
                    dim_w = {16'h0000, r_s_hdr[7], r_s_hdr[6]};
                    dim_h = {16'h0000, r_s_hdr[9], r_s_hdr[8]};
                end
                mhc_pkg::FMT_BMP: begin
                    dim_w = {r_s_hdr[21], r_s_hdr[20], r_s_hdr[19], r_s_hdr[18]};
                    dim_h = bmp_h[31] ? (~bmp_h + 32'd1) : bmp_h;
                end
                default: begin
                    dim_w = '0;
                    dim_h = '0;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_adv) begin
            r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s_valid) begin
            r_o_fmt    <= fmt;
            r_o_cls    <= cls;
            r_o_width  <= dim_w;
            r_o_height <= dim_h;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_format_code  = r_o_fmt;
    assign o_media_class  = r_o_cls;
    assign o_pixel_width  = r_o_width;
    assign o_pixel_height = r_o_height;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // A last byte always lands in the snapshot stage
    a_last_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && in_last |=> r_s_valid)
        else $error("last byte not captured into snapshot stage");

    // Byte count restarts after every file
    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && in_last |=> r_pos == '0)
        else $error("byte count not cleared at end of file");

    // A new result only ever comes from a held snapshot
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_s_valid))
        else $error("result appeared without a finished file");

    // Results for files that are not images always report zero dimensions
    a_dims_image_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_cls != mhc_pkg::CLS_IMAGE |-> r_o_width == '0 && r_o_height == '0)
        else $error("dimensions reported for a non-image format");

endmodule
